// ----- rtl/sorted_route_break_table_core_macros.svh -----
// Assertion helpers for the route break table.
`ifndef SORTED_ROUTE_BREAK_TABLE_CORE_MACROS_SVH
`define SORTED_ROUTE_BREAK_TABLE_CORE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SRBT_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as its antecedent.
`define SRBT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- rtl/srbt_pkg.sv -----
`default_nettype none
package srbt_pkg;

   localparam int TABLE_ENTRIES_DEF = 32;
   localparam int ADDR_W_FIELD      = 32;
   localparam int COUNT_OUT_W       = 6;
   localparam int CSR_INDEX_W       = 2;

   localparam logic [2:0] CMD_CREATE = 3'd0;
   localparam logic [2:0] CMD_FIND   = 3'd1;
   localparam logic [2:0] CMD_EXPIRE = 3'd2;
   localparam logic [2:0] CMD_REMOVE = 3'd3;
   localparam logic [2:0] CMD_FLUSH  = 3'd4;
   localparam logic [2:0] CMD_CLEAR  = 3'd5;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_NOMATCH = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_LINK_TIMEOUT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELETE_PERIOD = 2'd1;

   localparam logic [31:0] LINK_TIMEOUT_RST  = 32'd3000;
   localparam logic [31:0] DELETE_PERIOD_RST = 32'd15000;

   typedef struct packed {
      logic [31:0] src;
      logic [31:0] dst;
      logic [31:0] hop;
      logic [31:0] reach;
      logic [31:0] deadline;
      logic        invalid;
   } rec_type;

   function automatic logic [31:0] swap_bytes(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage
`default_nettype wire

// ----- rtl/srbt_mem.sv -----
`default_nettype none
// Record store: one write port, one read port, registered read data.
module srbt_mem #(
   parameter int DEPTH  = srbt_pkg::TABLE_ENTRIES_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire                  clock,
   input  wire                  wr_en,
   input  wire [ADDR_W-1:0]     wr_addr,
   input  wire srbt_pkg::rec_type wr_data,
   input  wire                  rd_en,
   input  wire [ADDR_W-1:0]     rd_addr,
   output srbt_pkg::rec_type    rd_data
);

   srbt_pkg::rec_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/sorted_route_break_table_core.sv -----
`default_nettype none
// Sorted route break table. Records sit in one memory in ascending order of
// destination; create, find, expire, remove and flush walk that memory with
// at most one read and one write per cycle, and the single read port sets the
// time of each request. Create walks down from the top to the insert position,
// and a full table is answered without a walk; find, expire and remove walk up
// to the matching slot, or to the fill count on a miss, with remove walking on
// to the end of the table; flush walks every record; clear and unknown
// commands do not walk the memory. One request is worked at a time; a new
// request is taken while the previous response still waits. The memory needs
// no clearing pass after reset: only slots below the fill count are read.
`include "sorted_route_break_table_core_macros.svh"
module sorted_route_break_table_core #(
   parameter int TABLE_ENTRIES = srbt_pkg::TABLE_ENTRIES_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   // request channel
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [2:0]                       req_command,
   input  wire  [31:0]                      req_src_address,
   input  wire  [31:0]                      req_dst_address,
   input  wire  [31:0]                      req_previous_hop,
   input  wire  [31:0]                      req_last_reachable,
   input  wire  [31:0]                      req_now_ms,
   // response channel
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic [31:0]                      rsp_rec_src,
   output logic [31:0]                      rsp_rec_dst,
   output logic [31:0]                      rsp_rec_hop,
   output logic [31:0]                      rsp_rec_reachable,
   output logic                             rsp_rec_invalid,
   output logic [31:0]                      rsp_rec_deadline,
   output logic [31:0]                      rsp_rec_dst_seq,
   output logic [5:0]                       rsp_aged_count,
   output logic [5:0]                       rsp_removed_count,
   output logic [5:0]                       rsp_entries_used,
   // configuration writes
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [srbt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire  [31:0]                      csr_data
);

   localparam int ADDR_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] USED_MAX = CNT_W'(TABLE_ENTRIES);

   typedef enum logic [2:0] {
      S_IDLE, S_CSCAN, S_MSCAN, S_COMPACT, S_WNEW, S_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [2:0]         cmd_ff, cmd_in;
   logic [31:0]        src_ff, src_in, dst_ff, dst_in, hop_ff, hop_in;
   logic [31:0]        reach_ff, reach_in, now_ff, now_in;
   logic [ADDR_W-1:0]  cur_ff, cur_in, wptr_ff, wptr_in;
   logic [CNT_W-1:0]   used_ff, used_in, aged_ff, aged_in, removed_ff, removed_in;
   srbt_pkg::rec_type  res_ff, res_in;
   logic [1:0]         status_ff, status_in;
   logic [31:0]        link_ff, link_in, delete_ff, delete_in;

   // response output register
   logic               rsp_valid_ff, rsp_valid_in;
   srbt_pkg::rec_type  rsp_rec_ff, rsp_rec_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]   rsp_aged_ff, rsp_aged_in, rsp_removed_ff, rsp_removed_in;
   logic [CNT_W-1:0]   rsp_used_ff, rsp_used_in;

   // memory port
   logic               mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]  mem_wr_addr, mem_rd_addr;
   srbt_pkg::rec_type  mem_wr_data, mem_rd_data;

   srbt_pkg::rec_type  new_rec, aged_rec;
   logic [31:0]        slack;
   logic               expired, is_flush, drop, match;
   logic [CNT_W-1:0]   cur_next, wnext;

   srbt_mem #(.DEPTH(TABLE_ENTRIES), .ADDR_W(ADDR_W)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Record built by create, and the aged form of the record just read.
   always_comb begin
      new_rec.src      = src_ff;
      new_rec.dst      = dst_ff;
      new_rec.hop      = hop_ff;
      new_rec.reach    = reach_ff;
      new_rec.deadline = now_ff + link_ff;
      new_rec.invalid  = 1'b0;
      aged_rec          = mem_rd_data;
      aged_rec.deadline = now_ff + delete_ff;
      aged_rec.invalid  = 1'b1;
   end

   // Wrap-safe deadline test: expired when deadline minus now is negative.
   assign slack    = mem_rd_data.deadline - now_ff;
   assign expired  = slack[31];
   assign is_flush = (cmd_ff == srbt_pkg::CMD_FLUSH);
   assign drop     = is_flush && expired && mem_rd_data.invalid;
   assign match    = (mem_rd_data.src == src_ff) && (mem_rd_data.dst == dst_ff);
   assign cur_next = CNT_W'(cur_ff) + CNT_W'(1);
   assign wnext    = drop ? CNT_W'(wptr_ff) : CNT_W'(wptr_ff) + CNT_W'(1);

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      hop_in     = hop_ff;
      reach_in   = reach_ff;
      now_in     = now_ff;
      cur_in     = cur_ff;
      wptr_in    = wptr_ff;
      used_in    = used_ff;
      aged_in    = aged_ff;
      removed_in = removed_ff;
      res_in     = res_ff;
      status_in  = status_ff;

      mem_wr_en   = 1'b0;
      mem_wr_addr = wptr_ff;
      mem_wr_data = mem_rd_data;
      mem_rd_en   = 1'b0;
      mem_rd_addr = cur_ff;

      // Drain the response register as soon as it is taken.
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_rec_in     = rsp_rec_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_aged_in    = rsp_aged_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_used_in    = rsp_used_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_command;
               src_in     = req_src_address;
               dst_in     = req_dst_address;
               hop_in     = req_previous_hop;
               reach_in   = req_last_reachable;
               now_in     = req_now_ms;
               aged_in    = '0;
               removed_in = '0;
               res_in     = '0;
               status_in  = srbt_pkg::STATUS_DONE;
               state_in   = S_FINISH;
               case (req_command)
                  srbt_pkg::CMD_CREATE: begin
                     if (used_ff == USED_MAX) begin
                        status_in = srbt_pkg::STATUS_FULL;
                     end else if (used_ff == '0) begin
                        wptr_in  = '0;
                        state_in = S_WNEW;
                     end else begin
                        // Walk down from the top, shifting records with equal or larger destination up.
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = ADDR_W'(used_ff - CNT_W'(1));
                        cur_in      = ADDR_W'(used_ff - CNT_W'(1));
                        wptr_in     = ADDR_W'(used_ff);
                        state_in    = S_CSCAN;
                     end
                  end
                  srbt_pkg::CMD_FIND, srbt_pkg::CMD_EXPIRE, srbt_pkg::CMD_REMOVE: begin
                     if (used_ff == '0) begin
                        status_in = srbt_pkg::STATUS_NOMATCH;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        cur_in      = '0;
                        state_in    = S_MSCAN;
                     end
                  end
                  srbt_pkg::CMD_FLUSH: begin
                     if (used_ff != '0) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        cur_in      = '0;
                        wptr_in     = '0;
                        state_in    = S_COMPACT;
                     end
                  end
                  srbt_pkg::CMD_CLEAR: begin
                     removed_in = used_ff;
                     used_in    = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_CSCAN: begin
            if (mem_rd_data.dst >= dst_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = wptr_ff;
               wptr_in     = cur_ff;
               if (cur_ff == '0) begin
                  state_in = S_WNEW;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = cur_ff - ADDR_W'(1);
                  cur_in      = cur_ff - ADDR_W'(1);
               end
            end else begin
               state_in = S_WNEW;
            end
         end

         S_WNEW: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = wptr_ff;
            mem_wr_data = new_rec;
            res_in      = new_rec;
            used_in     = used_ff + CNT_W'(1);
            state_in    = S_FINISH;
         end

         S_MSCAN: begin
            if (match) begin
               res_in   = mem_rd_data;
               state_in = S_FINISH;
               if (cmd_ff == srbt_pkg::CMD_EXPIRE) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = cur_ff;
                  mem_wr_data = aged_rec;
                  res_in      = aged_rec;
               end else if (cmd_ff == srbt_pkg::CMD_REMOVE) begin
                  if (cur_next < used_ff) begin
                     // Close the gap: copy the tail down one slot.
                     wptr_in     = cur_ff;
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = ADDR_W'(cur_next);
                     cur_in      = ADDR_W'(cur_next);
                     state_in    = S_COMPACT;
                  end else begin
                     used_in = used_ff - CNT_W'(1);
                  end
               end
            end else if (cur_next < used_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ADDR_W'(cur_next);
               cur_in      = ADDR_W'(cur_next);
            end else begin
               status_in = srbt_pkg::STATUS_NOMATCH;
               state_in  = S_FINISH;
            end
         end

         S_COMPACT: begin
            // Reads run ahead of writes, so a write never hits a slot still unread.
            if (drop) begin
               removed_in = removed_ff + CNT_W'(1);
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = wptr_ff;
               if (is_flush && expired) begin
                  mem_wr_data = aged_rec;
                  aged_in     = aged_ff + CNT_W'(1);
               end
            end
            if (cur_next < used_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ADDR_W'(cur_next);
               cur_in      = ADDR_W'(cur_next);
               wptr_in     = ADDR_W'(wnext);
            end else begin
               used_in  = wnext;
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            // Hold here until the response register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_rec_in     = res_ff;
               rsp_status_in  = status_ff;
               rsp_aged_in    = aged_ff;
               rsp_removed_in = removed_ff;
               rsp_used_in    = used_ff;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Configuration registers; writes beyond the list are dropped.
   always_comb begin
      link_in   = link_ff;
      delete_in = delete_ff;
      if (csr_valid) begin
         case (csr_index)
            srbt_pkg::CSR_LINK_TIMEOUT:  link_in   = csr_data;
            srbt_pkg::CSR_DELETE_PERIOD: delete_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         link_ff      <= srbt_pkg::LINK_TIMEOUT_RST;
         delete_ff    <= srbt_pkg::DELETE_PERIOD_RST;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         link_ff      <= link_in;
         delete_ff    <= delete_in;
      end
      cmd_ff         <= cmd_in;
      src_ff         <= src_in;
      dst_ff         <= dst_in;
      hop_ff         <= hop_in;
      reach_ff       <= reach_in;
      now_ff         <= now_in;
      cur_ff         <= cur_in;
      wptr_ff        <= wptr_in;
      aged_ff        <= aged_in;
      removed_ff     <= removed_in;
      res_ff         <= res_in;
      status_ff      <= status_in;
      rsp_rec_ff     <= rsp_rec_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_aged_ff    <= rsp_aged_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_used_ff    <= rsp_used_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_rec_src       = rsp_rec_ff.src;
   assign rsp_rec_dst       = rsp_rec_ff.dst;
   assign rsp_rec_hop       = rsp_rec_ff.hop;
   assign rsp_rec_reachable = rsp_rec_ff.reach;
   assign rsp_rec_invalid   = rsp_rec_ff.invalid;
   assign rsp_rec_deadline  = rsp_rec_ff.deadline;
   assign rsp_rec_dst_seq   = srbt_pkg::swap_bytes(rsp_rec_ff.dst);
   assign rsp_aged_count    = srbt_pkg::COUNT_OUT_W'(rsp_aged_ff);
   assign rsp_removed_count = srbt_pkg::COUNT_OUT_W'(rsp_removed_ff);
   assign rsp_entries_used  = srbt_pkg::COUNT_OUT_W'(rsp_used_ff);

   `SRBT_ASSERT_ALWAYS(a_used_bound, clock, reset, used_ff <= USED_MAX, "fill count overflow")
   `SRBT_ASSERT_IMP(a_write_in_fill, clock, reset, mem_wr_en, (CNT_W+1)'(mem_wr_addr) <= (CNT_W+1)'(used_ff), "write beyond fill")
   `SRBT_ASSERT_IMP(a_fail_counts, clock, reset, rsp_valid_ff && (rsp_status_ff != srbt_pkg::STATUS_DONE), (rsp_aged_ff == '0) && (rsp_removed_ff == '0), "counts on failed request")

endmodule
`default_nettype wire
